// ----- rtl/i2c_timing_prescaler_search_top_macros.svh -----
// assertion macros for the i2c timing prescaler search block
`ifndef I2C_TIMING_PRESCALER_SEARCH_TOP_MACROS_SVH
`define I2C_TIMING_PRESCALER_SEARCH_TOP_MACROS_SVH
`ifndef SYNTH
`define I2CPSC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define I2CPSC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define I2CPSC_ASSERT(lbl, clk, rst_n, prop, msg)
`define I2CPSC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ----- rtl/i2cpsc_pkg.sv -----
// shared types and constants for the i2c timing prescaler search
package i2cpsc_pkg;

    localparam int DIV_W   = 30;
    localparam int COUNT_W = 13;
    localparam int PSC_W   = 4;

    localparam logic [DIV_W-1:0] NS_PER_SEC = 30'd1000000000;

    localparam logic [1:0] MODE_STD  = 2'd0;
    localparam logic [1:0] MODE_FAST = 2'd1;

    // minimum times in ns
    localparam logic [COUNT_W-1:0] T_HIGH_STD  = 13'd4000;
    localparam logic [COUNT_W-1:0] T_LOW_STD   = 13'd4700;
    localparam logic [COUNT_W-1:0] T_HOLD_STD  = 13'd500;
    localparam logic [COUNT_W-1:0] T_SETUP_STD = 13'd1250;
    localparam logic [COUNT_W-1:0] T_HIGH_FST  = 13'd600;
    localparam logic [COUNT_W-1:0] T_LOW_FST   = 13'd1300;
    localparam logic [COUNT_W-1:0] T_HOLD_FST  = 13'd375;
    localparam logic [COUNT_W-1:0] T_SETUP_FST = 13'd500;

    localparam logic [COUNT_W-1:0] PERIOD_MAX = 13'd256;
    localparam logic [COUNT_W-1:0] HOLD_MAX   = 13'd15;
    localparam logic [COUNT_W-1:0] SETUP_MAX  = 13'd16;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_MODE = 2'd1,
        ST_NO_FIT   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        OP_T,
        OP_NS,
        OP_H,
        OP_L,
        OP_HD,
        OP_SU
    } t_div_op;

    typedef struct packed {
        logic    div_start;
        t_div_op op;
        logic    p_inc;
        logic    out_wr;
        t_status code;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic q_zero;
        logic fit;
        logic p_last;
        logic out_full;
        logic mode_bad;
    } t_stat;

endpackage

// ----- rtl/i2cpsc_div.sv -----
// iterative restoring divider, one quotient bit per cycle
module i2cpsc_div #(
    parameter int W = 30
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient
);
    localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [W:0] n_shift;
    logic [W:0] n_diff;

    assign n_shift = {r_rem, r_quo[W-1]};
    assign n_diff  = n_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!n_diff[W]) begin
                r_rem <= n_diff[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= n_shift[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// ----- rtl/i2cpsc_datapath.sv -----
// operand registers, shared divider, fit check and result register
module i2cpsc_datapath #(
    parameter int MAX_PRESCALER = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  logic [i2cpsc_pkg::DIV_W-1:0] i_clock_hz,
    input  logic                       i_cfg_wr,
    input  logic [1:0]                 i_speed_mode,
    input  i2cpsc_pkg::t_cmd           i_cmd,
    output i2cpsc_pkg::t_stat          o_stat,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [1:0]                 o_status,
    output logic [3:0]                 o_prescaler_code,
    output logic [3:0]                 o_setup_delay_code,
    output logic [3:0]                 o_hold_delay_code,
    output logic [7:0]                 o_high_period_code,
    output logic [7:0]                 o_low_period_code,
    output logic [31:0]                o_timing_word
);
    import i2cpsc_pkg::*;

    logic [1:0]         r_speed_mode;
    logic [DIV_W-1:0]   r_clk;
    logic [PSC_W-1:0]   r_p;
    logic [DIV_W-1:0]   r_t;
    logic [DIV_W-1:0]   r_ns;
    logic [COUNT_W-1:0] r_h;
    logic [COUNT_W-1:0] r_l;
    logic [COUNT_W-1:0] r_hd;
    logic [COUNT_W-1:0] r_su;

    logic               r_out_valid;
    t_status            r_status;
    logic [3:0]         r_psc_code;
    logic [3:0]         r_su_code;
    logic [3:0]         r_hd_code;
    logic [7:0]         r_h_code;
    logic [7:0]         r_l_code;

    logic [DIV_W-1:0]   n_dividend;
    logic [DIV_W-1:0]   n_divisor;
    logic               div_done;
    logic [DIV_W-1:0]   div_q;
    logic               fast;
    logic [COUNT_W-1:0] c_high;
    logic [COUNT_W-1:0] c_low;
    logic [COUNT_W-1:0] c_hold;
    logic [COUNT_W-1:0] c_setup;

    assign fast    = (r_speed_mode == MODE_FAST);
    assign c_high  = fast ? T_HIGH_FST  : T_HIGH_STD;
    assign c_low   = fast ? T_LOW_FST   : T_LOW_STD;
    assign c_hold  = fast ? T_HOLD_FST  : T_HOLD_STD;
    assign c_setup = fast ? T_SETUP_FST : T_SETUP_STD;

    always_comb begin
        unique case (i_cmd.op)
            OP_T: begin
                n_dividend = r_clk;
                n_divisor  = DIV_W'(r_p);
            end
            OP_NS: begin
                n_dividend = NS_PER_SEC;
                n_divisor  = r_t;
            end
            OP_H: begin
                n_dividend = DIV_W'(c_high);
                n_divisor  = r_ns;
            end
            OP_L: begin
                n_dividend = DIV_W'(c_low);
                n_divisor  = r_ns;
            end
            OP_HD: begin
                n_dividend = DIV_W'(c_hold);
                n_divisor  = r_ns;
            end
            OP_SU: begin
                n_dividend = DIV_W'(c_setup);
                n_divisor  = r_ns;
            end
            default: begin
                n_dividend = r_clk;
                n_divisor  = DIV_W'(r_p);
            end
        endcase
    end

    i2cpsc_div #(
        .W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (n_dividend),
        .i_divisor  (n_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_mode <= MODE_STD;
        end else if (i_cfg_wr) begin
            r_speed_mode <= i_speed_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_clk <= i_clock_hz;
            r_p   <= PSC_W'(1);
        end else if (i_cmd.p_inc) begin
            r_p <= r_p + 1'b1;
        end
        // quotients above the count range only need to stay above it
        if (div_done) begin
            unique case (i_cmd.op)
                OP_T:    r_t  <= div_q;
                OP_NS:   r_ns <= div_q;
                OP_H:    r_h  <= (div_q > DIV_W'(T_LOW_STD)) ? T_LOW_STD : div_q[COUNT_W-1:0];
                OP_L:    r_l  <= (div_q > DIV_W'(T_LOW_STD)) ? T_LOW_STD : div_q[COUNT_W-1:0];
                OP_HD:   r_hd <= (div_q > DIV_W'(T_LOW_STD)) ? T_LOW_STD : div_q[COUNT_W-1:0];
                OP_SU:   r_su <= (div_q > DIV_W'(T_LOW_STD)) ? T_LOW_STD : div_q[COUNT_W-1:0];
                default: r_t  <= div_q;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_wr) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_wr) begin
            r_status <= i_cmd.code;
            if (i_cmd.code == ST_OK) begin
                r_psc_code <= r_p - 1'b1;
                r_su_code  <= 4'(r_su - 1'b1);
                r_hd_code  <= r_hd[3:0];
                r_h_code   <= 8'(r_h - 1'b1);
                r_l_code   <= 8'(r_l - 1'b1);
            end else begin
                r_psc_code <= '0;
                r_su_code  <= '0;
                r_hd_code  <= '0;
                r_h_code   <= '0;
                r_l_code   <= '0;
            end
        end
    end

    assign o_stat.div_done = div_done;
    assign o_stat.q_zero   = (div_q == '0);
    assign o_stat.fit      = (r_h != '0) && (r_h <= PERIOD_MAX)
                          && (r_l != '0) && (r_l <= PERIOD_MAX)
                          && (r_hd <= HOLD_MAX)
                          && (r_su != '0) && (r_su <= SETUP_MAX);
    assign o_stat.p_last   = (r_p == PSC_W'(MAX_PRESCALER - 1));
    assign o_stat.out_full = r_out_valid;
    assign o_stat.mode_bad = (r_speed_mode != MODE_STD) && (r_speed_mode != MODE_FAST);

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_prescaler_code   = r_psc_code;
    assign o_setup_delay_code = r_su_code;
    assign o_hold_delay_code  = r_hd_code;
    assign o_high_period_code = r_h_code;
    assign o_low_period_code  = r_l_code;
    assign o_timing_word      = {r_psc_code, 4'd0, r_su_code, r_hd_code, r_h_code, r_l_code};
endmodule

// ----- rtl/i2cpsc_ctrl.sv -----
// sequencer for the prescaler trials and division order
module i2cpsc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  i2cpsc_pkg::t_stat i_stat,
    output i2cpsc_pkg::t_cmd  o_cmd,
    output logic              o_in_ready
);
    import i2cpsc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WAIT,
        S_NEXT,
        S_EVAL,
        S_FINISH
    } t_state;

    t_state r_state;
    t_cmd   r_cmd;
    logic   r_in_ready;

    function automatic t_div_op next_op(input t_div_op op);
        unique case (op)
            OP_T:    next_op = OP_NS;
            OP_NS:   next_op = OP_H;
            OP_H:    next_op = OP_L;
            OP_L:    next_op = OP_HD;
            OP_HD:   next_op = OP_SU;
            default: next_op = OP_SU;
        endcase
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
            r_cmd      <= '{div_start: 1'b0, op: OP_T, p_inc: 1'b0, out_wr: 1'b0, code: ST_OK};
        end else begin
            r_cmd.div_start <= 1'b0;
            r_cmd.p_inc     <= 1'b0;
            r_cmd.out_wr    <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_accept) begin
                        r_in_ready <= 1'b0;
                        if (i_stat.mode_bad) begin
                            r_cmd.code <= ST_BAD_MODE;
                            r_state    <= S_FINISH;
                        end else begin
                            r_cmd.op        <= OP_T;
                            r_cmd.div_start <= 1'b1;
                            r_state         <= S_WAIT;
                        end
                    end
                end
                S_WAIT: begin
                    if (i_stat.div_done) begin
                        // zero clock or zero period rejects this prescaler
                        priority if ((r_cmd.op == OP_T || r_cmd.op == OP_NS) && i_stat.q_zero) begin
                            if (i_stat.p_last) begin
                                r_cmd.code <= ST_NO_FIT;
                                r_state    <= S_FINISH;
                            end else begin
                                r_cmd.p_inc <= 1'b1;
                                r_state     <= S_NEXT;
                            end
                        end else if (r_cmd.op == OP_SU) begin
                            r_state <= S_EVAL;
                        end else begin
                            r_cmd.op        <= next_op(r_cmd.op);
                            r_cmd.div_start <= 1'b1;
                        end
                    end
                end
                S_NEXT: begin
                    r_cmd.op        <= OP_T;
                    r_cmd.div_start <= 1'b1;
                    r_state         <= S_WAIT;
                end
                S_EVAL: begin
                    priority if (i_stat.fit) begin
                        r_cmd.code <= ST_OK;
                        r_state    <= S_FINISH;
                    end else if (i_stat.p_last) begin
                        r_cmd.code <= ST_NO_FIT;
                        r_state    <= S_FINISH;
                    end else begin
                        r_cmd.p_inc <= 1'b1;
                        r_state     <= S_NEXT;
                    end
                end
                S_FINISH: begin
                    if (!i_stat.out_full) begin
                        r_cmd.out_wr <= 1'b1;
                        r_in_ready   <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cmd      = r_cmd;
    assign o_in_ready = r_in_ready;
endmodule

// ----- rtl/i2c_timing_prescaler_search_top.sv -----
// top level: i2c scl timing search over prescalers with a shared divider
// each prescaler trial runs up to six divisions on the shared divider, and
//   up to 15 trials are made, one per prescaler value from 1 to 15
// an invalid speed mode skips the divisions and returns ST_BAD_MODE
// one transaction at a time; the divider yields one quotient bit per cycle
// synchronous active-low reset clears control state and sets speed mode to 0
`include "i2c_timing_prescaler_search_top_macros.svh"
module i2c_timing_prescaler_search_top #(
    parameter int MAX_PRESCALER = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [29:0] i_clock_hz,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [3:0]  o_prescaler_code,
    output logic [3:0]  o_setup_delay_code,
    output logic [3:0]  o_hold_delay_code,
    output logic [7:0]  o_high_period_code,
    output logic [7:0]  o_low_period_code,
    output logic [31:0] o_timing_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_speed_mode
);
    import i2cpsc_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  accept;

    assign accept      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    i2cpsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    i2cpsc_datapath #(
        .MAX_PRESCALER (MAX_PRESCALER)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_load             (accept),
        .i_clock_hz         (i_clock_hz),
        .i_cfg_wr           (i_cfg_valid && o_cfg_ready),
        .i_speed_mode       (i_speed_mode),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_status           (o_status),
        .o_prescaler_code   (o_prescaler_code),
        .o_setup_delay_code (o_setup_delay_code),
        .o_hold_delay_code  (o_hold_delay_code),
        .o_high_period_code (o_high_period_code),
        .o_low_period_code  (o_low_period_code),
        .o_timing_word      (o_timing_word)
    );

    `I2CPSC_ASSERT(a_err_word_zero, i_clk, i_rst_n, (o_out_valid && (o_status != ST_OK)) |-> (o_timing_word == 32'd0), "error result carries nonzero timing word")
    `I2CPSC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, accept, !o_in_ready, "input ready while a transaction is in flight")
    `I2CPSC_ASSERT(a_psc_in_range, i_clk, i_rst_n, (o_out_valid && (o_status == ST_OK)) |-> (o_prescaler_code <= 4'(MAX_PRESCALER - 2)), "prescaler code beyond search range")
endmodule
